// ===== rtl/alpha_deghost_pixel_blend_top_defines.svh =====
// Assertion macros shared by the blend checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ALPHA_DEGHOST_PIXEL_BLEND_TOP_DEFINES_SVH
`define ALPHA_DEGHOST_PIXEL_BLEND_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADA_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ada_pkg.sv =====
// Types, constants and ROM builders for the deghost pixel blend.
// No dependencies; every RTL module imports this package.
`default_nettype none

package ada_pkg;

  localparam int WFB      = 16;          // fraction bits of the blend weights
  localparam int WGT_W    = WFB + 1;     // weights run 0..1.0 inclusive
  localparam int PIX_W    = 8;
  localparam int DIFF_MAX = 765;
  localparam int DIFF_W   = 10;
  localparam int NSTG     = 6;
  localparam int OCC_W    = $clog2(NSTG + 1);

  // (255 - t) * (1 - g) and s * g product widths
  localparam int PROD_W   = WFB + 8;
  localparam int SG_W     = 2 * WFB + 1;
  // floor(x / 255) = (x * RCP_MUL) >> RCP_SH, exact for x < 2^PROD_W
  localparam int RCP_SH   = PROD_W + 8;
  localparam int RCP_W    = WFB + 9;
  localparam int CMP_W    = WFB + 9;

  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((64'd1 << RCP_SH) + 64'd254) / 64'd255);
  localparam logic [WGT_W-1:0] WGT_ONE  = {1'b1, {WFB{1'b0}}};
  localparam logic [SG_W-1:0]  SG_HALF  = SG_W'(1) << (WFB - 1);
  localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;

  localparam logic [63:0] ONE32   = 64'h1_0000_0000;
  localparam logic [63:0] HALF32  = 64'h8000_0000;
  localparam logic [63:0] EPS_Q32 = 64'd42950;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [WGT_W-1:0]  wgt_t;
  typedef logic [DIFF_W-1:0] diff_t;
  typedef logic [63:0]       q32_t;

  typedef wgt_t tanh_tab_t [DIFF_MAX+1];
  typedef wgt_t soft_tab_t [256];
  typedef q32_t exp_frac_t [255];
  typedef q32_t exp_int_t  [31];

  typedef struct packed {
    pix_t base_blue;
    pix_t base_green;
    pix_t base_red;
    pix_t top_blue;
    pix_t top_green;
    pix_t top_red;
    pix_t opacity;
  } pix_set_t;

  typedef struct packed {
    logic [NSTG-1:0] adv;
  } pipe_ctl_t;

  function automatic q32_t mul_q32(input q32_t a, input q32_t b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + {64'd0, HALF32};
    return p[95:32];
  endfunction

  // Shift-and-subtract quotient; only used while building the ROMs.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-n/255) for n = 0..254, Q0.32
  function automatic exp_frac_t calc_exp_frac();
    exp_frac_t ef;
    logic [63:0] term;
    logic [63:0] acc;
    term = 64'd1 << 62;
    acc  = term;
    for (int k = 1; k <= 8; k++) begin
      term = div_u64(term, 64'd255 * 64'(k));
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    ef[0] = ONE32;
    ef[1] = (acc + (64'd1 << 29)) >> 30;
    for (int i = 2; i < 255; i++) begin
      ef[i] = mul_q32(ef[i-1], ef[1]);
    end
    return ef;
  endfunction

  // exp(-q) for q = 0..30, Q0.32
  function automatic exp_int_t calc_exp_int(input exp_frac_t ef);
    exp_int_t ei;
    ei[0] = ONE32;
    ei[1] = mul_q32(ef[254], ef[1]);
    for (int i = 2; i < 31; i++) begin
      ei[i] = mul_q32(ei[i-1], ei[1]);
    end
    return ei;
  endfunction

  function automatic q32_t exp_neg(input int unsigned n, input exp_frac_t ef,
                                   input exp_int_t ei);
    int unsigned q;
    int unsigned r;
    q = 32'(div_u64(64'(n), 64'd255));
    r = n - q * 32'd255;
    if (q > 30) begin
      return 64'd0;
    end
    if (q == 0) begin
      return ef[r];
    end
    if (r == 0) begin
      return ei[q];
    end
    return mul_q32(ei[q], ef[r]);
  endfunction

  // tanh(5*d/255) per color difference d
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t tab;
    exp_frac_t ef;
    exp_int_t ei;
    q32_t e;
    logic [63:0] nm;
    logic [63:0] dn;
    ef = calc_exp_frac();
    ei = calc_exp_int(ef);
    for (int i = 0; i <= DIFF_MAX; i++) begin
      e  = exp_neg(10 * i, ef, ei);
      nm = (ONE32 - e) << WFB;
      dn = ONE32 + e;
      tab[i] = WGT_W'(div_u64(nm + (dn >> 1), dn));
    end
    return tab;
  endfunction

  // base-biased softmax weight per top alpha
  function automatic soft_tab_t build_soft();
    soft_tab_t tab;
    exp_frac_t ef;
    exp_int_t ei;
    q32_t num;
    q32_t den;
    logic [63:0] nm;
    logic [63:0] dn;
    ef = calc_exp_frac();
    ei = calc_exp_int(ef);
    for (int i = 0; i < 256; i++) begin
      if (15 * i <= 2550) begin
        num = ONE32;
        den = ONE32 + exp_neg(2550 - 15 * i, ef, ei)
            + mul_q32(EPS_Q32, exp_neg(2550 - 10 * i, ef, ei));
      end else begin
        num = exp_neg(15 * i - 2550, ef, ei);
        den = num + ONE32 + mul_q32(EPS_Q32, exp_neg(5 * i, ef, ei));
      end
      nm = num << WFB;
      dn = den;
      tab[i] = WGT_W'(div_u64(nm + (dn >> 1), dn));
    end
    return tab;
  endfunction

  function automatic pix_t abs_diff(input pix_t a, input pix_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ada_ctrl.sv =====
// Valid-bit chain and per-stage advance for the blend pipeline.
// Depends on ada_pkg.
`default_nettype none

module ada_ctrl import ada_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] adv;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = adv[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.adv   = adv;
  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/ada_diff.sv =====
// Stage 1: color difference sum, alpha max and pixel capture.
// Depends on ada_pkg.
`default_nettype none

module ada_diff import ada_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  pix_t      base_blue,
  input  pix_t      base_green,
  input  pix_t      base_red,
  input  pix_t      base_opacity,
  input  pix_t      top_blue,
  input  pix_t      top_green,
  input  pix_t      top_red,
  input  pix_t      top_opacity,
  output diff_t     diff_r,
  output pix_t      top_op_r,
  output pix_set_t  pix_r
);

  diff_t    diff_nxt;
  pix_set_t pix_nxt;

  always_comb begin
    diff_nxt = DIFF_W'(abs_diff(base_blue, top_blue))
             + DIFF_W'(abs_diff(base_green, top_green))
             + DIFF_W'(abs_diff(base_red, top_red));
    pix_nxt.base_blue  = base_blue;
    pix_nxt.base_green = base_green;
    pix_nxt.base_red   = base_red;
    pix_nxt.top_blue   = top_blue;
    pix_nxt.top_green  = top_green;
    pix_nxt.top_red    = top_red;
    pix_nxt.opacity    = (base_opacity > top_opacity) ? base_opacity : top_opacity;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      diff_r   <= diff_nxt;
      top_op_r <= top_opacity;
      pix_r    <= pix_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ada_weight.sv =====
// Stages 2-5: tanh and softmax ROM reads, weight products, divide by 255.
// Depends on ada_pkg (ROM builders and weight widths).
`default_nettype none

module ada_weight import ada_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  diff_t     diff,
  input  pix_t      top_op,
  output wgt_t      wb_r
);

  localparam tanh_tab_t TANH_ROM = build_tanh();
  localparam soft_tab_t SOFT_ROM = build_soft();

  localparam int QP_W = PROD_W + RCP_W;

  // stage 2
  wgt_t              g_r;
  wgt_t              s_r;
  pix_t              t2_r;
  // stage 3
  logic [PROD_W-1:0] a_r;
  logic [SG_W-1:0]   b_r;
  logic [PROD_W-1:0] a_nxt;
  logic [SG_W-1:0]   b_nxt;
  // stage 4
  logic [PROD_W-1:0] a4_r;
  logic [SG_W-1:0]   c4_r;
  wgt_t              q_r;
  logic [QP_W-1:0]   qp;
  wgt_t              q_nxt;
  // stage 5
  logic [PROD_W-1:0] rem_full;
  logic [7:0]        rem;
  wgt_t              ch;
  logic [WFB-1:0]    cl;
  logic [CMP_W-1:0]  lhs;
  logic [CMP_W-1:0]  thr;
  logic              carry;
  logic [WGT_W:0]    wb_sum;
  wgt_t              wb_nxt;

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      g_r  <= TANH_ROM[diff];
      s_r  <= SOFT_ROM[top_op];
      t2_r <= top_op;
    end
  end

  // A = (255 - t) * (1 - g), B = s * g
  always_comb begin
    a_nxt = PROD_W'(PROD_W'(PIX_MAX - t2_r) * PROD_W'(WGT_ONE - g_r));
    b_nxt = SG_W'(SG_W'(s_r) * SG_W'(g_r));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  // Quotient of A by 255 through the reciprocal; C = B plus rounding half.
  always_comb begin
    qp    = QP_W'(a_r) * QP_W'(RCP_MUL);
    q_nxt = WGT_W'(qp >> RCP_SH);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      a4_r <= a_r;
      c4_r <= b_r + SG_HALF;
      q_r  <= q_nxt;
    end
  end

  // wb = floor(C / 2^F) + floor(A / 255) + carry of the two remainders
  always_comb begin
    rem_full = a4_r - (PROD_W'({q_r, 8'd0}) - PROD_W'(q_r));
    rem      = rem_full[7:0];
    ch       = WGT_W'(c4_r >> WFB);
    cl       = c4_r[WFB-1:0];
    lhs      = CMP_W'({rem, {WFB{1'b0}}}) + CMP_W'({cl, 8'd0}) - CMP_W'(cl);
    thr      = CMP_W'({PIX_MAX, {WFB{1'b0}}});
    carry    = (lhs >= thr);
    wb_sum   = (WGT_W + 1)'(ch) + (WGT_W + 1)'(q_r) + (WGT_W + 1)'(carry);
    wb_nxt   = wb_sum[WGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      wb_r <= wb_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ada_mix.sv =====
// Pixel delay line for stages 2-5 and the stage 6 channel blend.
// Depends on ada_pkg.
`default_nettype none

module ada_mix import ada_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  pix_set_t  pix,
  input  wgt_t      wb,
  output pix_t      merged_blue_r,
  output pix_t      merged_green_r,
  output pix_t      merged_red_r,
  output pix_t      merged_opacity_r
);

  localparam int DLY = 4;
  localparam int SUM_W = WFB + 8;

  pix_set_t dly_r [DLY];
  pix_set_t cur;
  wgt_t     wt;

  function automatic pix_t blend(input pix_t b, input pix_t t, input wgt_t wbase,
                                 input wgt_t wtop);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(SUM_W'(b) * SUM_W'(wbase)) + SUM_W'(SUM_W'(t) * SUM_W'(wtop));
    return sum[SUM_W-1:WFB];
  endfunction

  // Pixels walk alongside the weight stages.
  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      dly_r[0] <= pix;
    end
    for (int i = 1; i < DLY; i++) begin
      if (ctl.adv[i+1]) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  always_comb begin
    cur = dly_r[DLY-1];
    wt  = WGT_ONE - wb;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[NSTG-1]) begin
      merged_blue_r    <= blend(cur.base_blue, cur.top_blue, wb, wt);
      merged_green_r   <= blend(cur.base_green, cur.top_green, wb, wt);
      merged_red_r     <= blend(cur.base_red, cur.top_red, wb, wt);
      merged_opacity_r <= cur.opacity;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/alpha_deghost_pixel_blend_top.sv =====
// Top level of the deghost pixel blend: control, difference, weight, mix.
// Depends on ada_pkg, ada_ctrl, ada_diff, ada_weight, ada_mix.
//
//   channel | ports                          | transfer when
//   --------+--------------------------------+-----------------------
//   in      | in_base_*, in_top_* (8b each)  | in_valid && in_ready
//   out     | out_merged_* (8b each)         | out_valid && out_ready
//
// Six register stages; one pixel enters every cycle while the output is
// taken. The ROM reads and the reciprocal multiply of the divide by 255
// set the stage split. Each stage holds its data when the next one is
// full and stalled; empty stages keep filling, so bubbles close up during
// a stall. Reset clears only the valid bits.
`default_nettype none

module alpha_deghost_pixel_blend_top import ada_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_base_blue,
  input  logic [7:0] in_base_green,
  input  logic [7:0] in_base_red,
  input  logic [7:0] in_base_opacity,
  input  logic [7:0] in_top_blue,
  input  logic [7:0] in_top_green,
  input  logic [7:0] in_top_red,
  input  logic [7:0] in_top_opacity,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_merged_blue,
  output logic [7:0] out_merged_green,
  output logic [7:0] out_merged_red,
  output logic [7:0] out_merged_opacity
);

  pipe_ctl_t ctl;
  diff_t     diff;
  pix_t      top_op;
  pix_set_t  pix;
  wgt_t      wb;

  ada_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  ada_diff u_diff (
    .clk          (clk),
    .ctl          (ctl),
    .base_blue    (in_base_blue),
    .base_green   (in_base_green),
    .base_red     (in_base_red),
    .base_opacity (in_base_opacity),
    .top_blue     (in_top_blue),
    .top_green    (in_top_green),
    .top_red      (in_top_red),
    .top_opacity  (in_top_opacity),
    .diff_r       (diff),
    .top_op_r     (top_op),
    .pix_r        (pix)
  );

  ada_weight u_weight (
    .clk    (clk),
    .ctl    (ctl),
    .diff   (diff),
    .top_op (top_op),
    .wb_r   (wb)
  );

  ada_mix u_mix (
    .clk              (clk),
    .ctl              (ctl),
    .pix              (pix),
    .wb               (wb),
    .merged_blue_r    (out_merged_blue),
    .merged_green_r   (out_merged_green),
    .merged_red_r     (out_merged_red),
    .merged_opacity_r (out_merged_opacity)
  );

endmodule

`default_nettype wire

// ===== rtl/ada_checker.sv =====
// Port-level checks for the deghost pixel blend, bound to the top level.
// Depends on ada_pkg and alpha_deghost_pixel_blend_top_defines.svh.
`default_nettype none
`include "alpha_deghost_pixel_blend_top_defines.svh"

module ada_checker import ada_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_merged_blue,
  input logic [7:0] out_merged_green,
  input logic [7:0] out_merged_red,
  input logic [7:0] out_merged_opacity
);

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  // track pixels in flight from the transfers seen on the ports
  always_comb begin
    occ_nxt = occ_r + OCC_W'(in_valid && in_ready) - OCC_W'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `ADA_HOLDS(a_ready_free, !out_valid || out_ready, in_ready, "input stalled with room free")
  `ADA_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_merged_blue) && $stable(out_merged_green) && $stable(out_merged_red) && $stable(out_merged_opacity), "stalled result changed")
  `ADA_HOLDS(a_no_phantom, out_valid, occ_r != '0, "result without a pixel in flight")
  `ADA_HOLDS(a_depth, 1'b1, occ_r <= OCC_W'(NSTG), "more pixels in flight than stages")

endmodule

bind alpha_deghost_pixel_blend_top ada_checker u_ada_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_merged_blue    (out_merged_blue),
  .out_merged_green   (out_merged_green),
  .out_merged_red     (out_merged_red),
  .out_merged_opacity (out_merged_opacity)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for alpha_deghost_pixel_blend_top: directed and random pixel pairs
// under random valid/ready gaps, each result checked against a bit-exact blend computed here.
// Depends on ada_pkg (weight fraction width) and the RTL of the blend.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = ada_pkg::WFB;
  localparam int RANDOM_PIXELS = 750;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic [7:0] base_blue;
    logic [7:0] base_green;
    logic [7:0] base_red;
    logic [7:0] base_opacity;
    logic [7:0] top_blue;
    logic [7:0] top_green;
    logic [7:0] top_red;
    logic [7:0] top_opacity;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] opacity;
  } blended_t;

  class blend_scoreboard;
    localparam bit [63:0] UNIT32 = 64'h1_0000_0000;
    localparam bit [63:0] EPS32 = 64'd42950;

    bit [63:0] exp_frac_q32 [255];
    bit [63:0] exp_whole_q32 [31];
    bit [FRAC:0] tanh_weight [766];
    bit [FRAC:0] soft_weight [256];
    blended_t queued_blends [$];
    int unsigned mismatches;

    function bit [63:0] q32_mul(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
      return p[95:32];
    endfunction

    // exp(-n/255) in Q0.32, split into whole and fractional steps
    function bit [63:0] exp_down(int unsigned n);
      int unsigned q;
      int unsigned r;
      q = n / 255;
      r = n % 255;
      if (q > 30) return 64'd0;
      if (q == 0) return exp_frac_q32[r];
      if (r == 0) return exp_whole_q32[q];
      return q32_mul(exp_whole_q32[q], exp_frac_q32[r]);
    endfunction

    function bit [63:0] round_div(bit [63:0] n, bit [63:0] d);
      return (n + d / 2) / d;
    endfunction

    function new();
      bit [63:0] term;
      bit [63:0] acc;
      bit [63:0] e;
      bit [63:0] num;
      bit [63:0] den;
      mismatches = 0;
      // Taylor sum of exp(-1/255) in Q0.62
      term = 64'd1 << 62;
      acc = term;
      for (int k = 1; k <= 8; k++) begin
        term = term / (64'd255 * 64'(k));
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      exp_frac_q32[0] = UNIT32;
      exp_frac_q32[1] = (acc + (64'd1 << 29)) >> 30;
      for (int i = 2; i < 255; i++)
        exp_frac_q32[i] = q32_mul(exp_frac_q32[i-1], exp_frac_q32[1]);
      exp_whole_q32[0] = UNIT32;
      exp_whole_q32[1] = q32_mul(exp_frac_q32[254], exp_frac_q32[1]);
      for (int i = 2; i < 31; i++)
        exp_whole_q32[i] = q32_mul(exp_whole_q32[i-1], exp_whole_q32[1]);

      for (int i = 0; i <= 765; i++) begin
        e = exp_down(10 * i);
        tanh_weight[i] = (FRAC+1)'(round_div((UNIT32 - e) << FRAC, UNIT32 + e));
      end
      for (int i = 0; i < 256; i++) begin
        if (15 * i <= 2550) begin
          num = UNIT32;
          den = UNIT32 + exp_down(2550 - 15 * i) + q32_mul(EPS32, exp_down(2550 - 10 * i));
        end else begin
          num = exp_down(15 * i - 2550);
          den = num + UNIT32 + q32_mul(EPS32, exp_down(5 * i));
        end
        soft_weight[i] = (FRAC+1)'(round_div(num << FRAC, den));
      end
    endfunction

    function int unsigned pix_gap(logic [7:0] a, logic [7:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function bit [7:0] mix_channel(logic [7:0] b, logic [7:0] t, bit [63:0] wb,
                                   bit [63:0] wt);
      bit [63:0] sum;
      sum = 64'(b) * wb + 64'(t) * wt;
      return sum[FRAC +: 8];
    endfunction

    function blended_t blend_pixel(pixel_pair_t p);
      blended_t r;
      int unsigned d;
      bit [63:0] one;
      bit [63:0] g;
      bit [63:0] s;
      bit [63:0] t;
      bit [63:0] num;
      bit [63:0] wb;
      bit [63:0] wt;
      one = 64'd1 << FRAC;
      d = pix_gap(p.base_blue, p.top_blue) + pix_gap(p.base_green, p.top_green)
        + pix_gap(p.base_red, p.top_red);
      t = 64'(p.top_opacity);
      g = 64'(tanh_weight[d]);
      s = 64'(soft_weight[p.top_opacity]);
      num = (64'd255 - t) * (one - g) * one + 64'd255 * s * g;
      wb = round_div(num, 64'd255 * one);
      wt = one - wb;
      r.blue = mix_channel(p.base_blue, p.top_blue, wb, wt);
      r.green = mix_channel(p.base_green, p.top_green, wb, wt);
      r.red = mix_channel(p.base_red, p.top_red, wb, wt);
      r.opacity = (p.base_opacity > p.top_opacity) ? p.base_opacity : p.top_opacity;
      return r;
    endfunction

    function void note_pixel(pixel_pair_t p);
      queued_blends.push_back(blend_pixel(p));
    endfunction

    function void compare_channel(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_blend(blended_t got);
      blended_t want;
      if (queued_blends.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = queued_blends.pop_front();
      compare_channel("blue", want.blue, got.blue);
      compare_channel("green", want.green, got.green);
      compare_channel("red", want.red, got.red);
      compare_channel("opacity", want.opacity, got.opacity);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pixel_pair_t in_px = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_merged_blue;
  logic [7:0] out_merged_green;
  logic [7:0] out_merged_red;
  logic [7:0] out_merged_opacity;

  bit steady = 1'b0;
  int unsigned quiet_cycles = 0;
  blend_scoreboard sb;

  always #5 clk = ~clk;

  alpha_deghost_pixel_blend_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_base_blue(in_px.base_blue),
    .in_base_green(in_px.base_green),
    .in_base_red(in_px.base_red),
    .in_base_opacity(in_px.base_opacity),
    .in_top_blue(in_px.top_blue),
    .in_top_green(in_px.top_green),
    .in_top_red(in_px.top_red),
    .in_top_opacity(in_px.top_opacity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_merged_blue(out_merged_blue),
    .out_merged_green(out_merged_green),
    .out_merged_red(out_merged_red),
    .out_merged_opacity(out_merged_opacity)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_blend({out_merged_blue, out_merged_green, out_merged_red, out_merged_opacity});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input pixel_pair_t p);
    if (!steady && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_px <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
  endtask

  // Hold the sender until every queued blend has come out.
  task automatic drain_blends();
    in_valid <= 1'b0;
    while (sb.queued_blends.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] near_value(logic [7:0] v);
    int x;
    x = int'(v) + int'($urandom_range(0, 12)) - 6;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return 8'(x);
  endfunction

  function automatic logic [7:0] pick_opacity();
    case ($urandom_range(0, 19))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd170;
      3: return 8'd171;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    int unsigned kind;
    p = {$urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // equal colors
      p.top_blue = p.base_blue;
      p.top_green = p.base_green;
      p.top_red = p.base_red;
    end else if (kind < 50) begin
      // small difference, steep part of the tanh curve
      p.top_blue = near_value(p.base_blue);
      p.top_green = near_value(p.base_green);
      p.top_red = near_value(p.base_red);
    end
    if ($urandom_range(0, 1) == 0) p.top_opacity = pick_opacity();
    return p;
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel({8'd12, 8'd200, 8'd77, 8'd30, 8'd12, 8'd200, 8'd77, 8'd220});
    send_pixel({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
    send_pixel({8'd100, 8'd100, 8'd100, 8'd80, 8'd101, 8'd100, 8'd100, 8'd128});
    send_pixel({8'd40, 8'd90, 8'd160, 8'd10, 8'd60, 8'd70, 8'd150, 8'd170});
    send_pixel({8'd40, 8'd90, 8'd160, 8'd250, 8'd60, 8'd70, 8'd150, 8'd171});
    send_pixel({8'd200, 8'd10, 8'd90, 8'd5, 8'd20, 8'd190, 8'd90, 8'd1});
    send_pixel({8'd200, 8'd10, 8'd90, 8'd5, 8'd20, 8'd190, 8'd90, 8'd254});
    send_pixel({8'd77, 8'd33, 8'd211, 8'd64, 8'd77, 8'd33, 8'd211, 8'd0});
    send_pixel({8'd77, 8'd33, 8'd211, 8'd64, 8'd77, 8'd33, 8'd211, 8'd170});
    send_pixel({8'd1, 8'd254, 8'd128, 8'd200, 8'd1, 8'd254, 8'd128, 8'd255});
    send_pixel({8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55, 8'h55});
    send_pixel({8'h55, 8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'hAA});
    send_pixel({8'd0, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128, 8'd128, 8'd100});
    send_pixel({8'd50, 8'd50, 8'd50, 8'd0, 8'd52, 8'd49, 8'd50, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd128});
    send_pixel({8'd30, 8'd60, 8'd90, 8'd255, 8'd31, 8'd60, 8'd90, 8'd0});
    drain_blends();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      steady = (i >= 250 && i < 400);
      if (i == 500) drain_blends();
      send_pixel(random_pair());
    end
    steady = 1'b0;
    drain_blends();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.queued_blends.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
